/* src/tkst_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the top-k score table.
package tkst_pkg;

  localparam int GROUPS  = 4;
  localparam int ENTRIES = 16;
  localparam int DEPTH   = GROUPS * ENTRIES;

  localparam int KIND_W  = 2;
  localparam int GROUP_W = 2;
  localparam int ID_W    = 32;
  localparam int SCORE_W = 32;
  localparam int DAY_W   = 16;

  localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Input stream packing, lowest bit first.
  localparam int S_GROUP_LSB = 0;
  localparam int S_ID_LSB    = S_GROUP_LSB + GROUP_W;
  localparam int S_SCORE_LSB = S_ID_LSB + ID_W;
  localparam int S_DAY_LSB   = S_SCORE_LSB + SCORE_W;
  localparam int S_FIELDS_W  = S_DAY_LSB + DAY_W;
  localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

  localparam int M_DATA_W = ID_W + SCORE_W;

  localparam logic [KIND_W-1:0] KIND_SUBMIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEAL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic load;       // latch the input transaction
    logic day_clear;  // start a new day for the addressed group
    logic seal;       // freeze the addressed group
    logic mem_rd;     // read the entry at the running index
    logic scan;       // the issued read feeds the submit scan
    logic idx_inc;    // advance the running index
    logic decide;     // apply the submit outcome
    logic out_ack;    // load an acknowledge into the output register
    logic out_entry;  // load the read entry into the output register
  } tkst_cmd_t;

  typedef struct packed {
    logic is_bad;
    logic is_submit;
    logic is_seal;
    logic day_diff;
    logic sealed;
    logic count_zero;
    logic idx_last;
    logic out_free;
  } tkst_status_t;

endpackage

/* src/tkst_ctrl.sv */
// Controller state machine that sequences submit scans, seals, read-outs and acknowledges.
module tkst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tkst_pkg::tkst_status_t status,
  output tkst_pkg::tkst_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_PREP    = 9'b000000010,
    ST_SCAN    = 9'b000000100,
    ST_DRAIN   = 9'b000001000,
    ST_DECIDE  = 9'b000010000,
    ST_ACK     = 9'b000100000,
    ST_RD_REQ  = 9'b001000000,
    ST_RD_DATA = 9'b010000000,
    ST_RD_HOLD = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        priority if (status.is_bad) begin
          state_next = ST_ACK;
        end else if (status.is_seal) begin
          cmd.seal   = 1'b1;
          state_next = ST_ACK;
        end else if (!status.is_submit) begin
          state_next = status.count_zero ? ST_ACK : ST_RD_REQ;
        end else if (status.day_diff) begin
          cmd.day_clear = 1'b1;
          state_next    = ST_DECIDE;
        end else if (status.sealed) begin
          state_next = ST_ACK;
        end else if (status.count_zero) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.mem_rd  = 1'b1;
        cmd.scan    = 1'b1;
        cmd.idx_inc = 1'b1;
        if (status.idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_ACK;
      end
      ST_ACK: begin
        if (status.out_free) begin
          cmd.out_ack = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_RD_REQ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        state_next = ST_RD_HOLD;
        if (status.out_free) begin
          cmd.out_entry = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = status.idx_last ? ST_IDLE : ST_RD_REQ;
        end
      end
      ST_RD_HOLD: begin
        if (status.out_free) begin
          cmd.out_entry = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = status.idx_last ? ST_IDLE : ST_RD_REQ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/tkst_dp.sv */
// Datapath: entry memories, per-group registers, scan accumulators and the output register.
module tkst_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  tkst_pkg::tkst_cmd_t                  cmd,
  output tkst_pkg::tkst_status_t               status,
  input  logic [tkst_pkg::KIND_W-1:0]          in_kind,
  input  logic [tkst_pkg::GROUP_W-1:0]         in_group,
  input  logic [tkst_pkg::ID_W-1:0]            in_player_id,
  input  logic [tkst_pkg::SCORE_W-1:0]         in_score,
  input  logic [tkst_pkg::DAY_W-1:0]           in_day_index,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_entry_valid,
  output logic [tkst_pkg::ID_W-1:0]            out_player_id,
  output logic [tkst_pkg::SCORE_W-1:0]         out_score,
  output logic                                out_last
);

  // Latched transaction.
  logic [tkst_pkg::KIND_W-1:0]  it_kind;
  logic [tkst_pkg::GROUP_W-1:0] it_group;
  logic [tkst_pkg::ID_W-1:0]    it_id;
  logic [tkst_pkg::SCORE_W-1:0] it_score;
  logic [tkst_pkg::DAY_W-1:0]   it_day;
  logic [tkst_pkg::GIDX_W-1:0]  gidx;

  // Per-group state.
  logic [tkst_pkg::CNT_W-1:0] grp_count [tkst_pkg::GROUPS];
  logic [tkst_pkg::IDX_W-1:0] grp_low   [tkst_pkg::GROUPS];
  logic                       grp_seal  [tkst_pkg::GROUPS];
  logic [tkst_pkg::DAY_W-1:0] grp_day   [tkst_pkg::GROUPS];

  logic [tkst_pkg::CNT_W-1:0] cur_count;
  logic [tkst_pkg::IDX_W-1:0] cur_low;

  // Entry memories.
  logic [tkst_pkg::ID_W-1:0]    id_mem    [tkst_pkg::DEPTH];
  logic [tkst_pkg::SCORE_W-1:0] score_mem [tkst_pkg::DEPTH];
  logic [tkst_pkg::ID_W-1:0]    rd_id;
  logic [tkst_pkg::SCORE_W-1:0] rd_score;
  logic [tkst_pkg::IDX_W-1:0]   rd_idx;
  logic [tkst_pkg::ADDR_W-1:0]  rd_addr;
  logic [tkst_pkg::ADDR_W-1:0]  wr_addr;
  logic [tkst_pkg::ADDR_W-1:0]  grp_base;

  logic [tkst_pkg::IDX_W-1:0] idx;
  logic                       scan_pend;

  // Scan accumulators.
  logic                         found;
  logic [tkst_pkg::IDX_W-1:0]   found_idx;
  logic [tkst_pkg::SCORE_W-1:0] found_score;
  logic [tkst_pkg::SCORE_W-1:0] low_score;
  logic                         second_ok;
  logic [tkst_pkg::SCORE_W-1:0] second;
  logic [tkst_pkg::IDX_W-1:0]   second_idx;

  // Decision results.
  logic                       wr_en;
  logic [tkst_pkg::IDX_W-1:0] wr_idx;
  logic                       low_we;
  logic [tkst_pkg::IDX_W-1:0] low_next;
  logic                       cnt_we;
  logic [tkst_pkg::CNT_W-1:0] cnt_next;
  logic                       full;

  assign gidx      = tkst_pkg::GIDX_W'(it_group);
  assign cur_count = grp_count[gidx];
  assign cur_low   = grp_low[gidx];
  assign grp_base  = tkst_pkg::ADDR_W'(gidx) * tkst_pkg::ADDR_W'(tkst_pkg::ENTRIES);
  assign rd_addr   = grp_base + tkst_pkg::ADDR_W'(idx);
  assign wr_addr   = grp_base + tkst_pkg::ADDR_W'(wr_idx);

  always_comb begin
    status            = '0;
    status.is_bad     = (it_kind != tkst_pkg::KIND_SUBMIT && it_kind != tkst_pkg::KIND_SEAL &&
                         it_kind != tkst_pkg::KIND_READ) ||
                        (32'(it_group) >= tkst_pkg::GROUPS);
    status.is_submit  = (it_kind == tkst_pkg::KIND_SUBMIT);
    status.is_seal    = (it_kind == tkst_pkg::KIND_SEAL);
    status.day_diff   = (grp_day[gidx] != it_day);
    status.sealed     = grp_seal[gidx];
    status.count_zero = (cur_count == '0);
    status.idx_last   = ((tkst_pkg::CNT_W'(idx) + tkst_pkg::CNT_W'(1)) == cur_count);
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_kind  <= in_kind;
      it_group <= in_group;
      it_id    <= in_player_id;
      it_score <= in_score;
      it_day   <= in_day_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      scan_pend <= 1'b0;
    end else begin
      scan_pend <= cmd.scan;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + tkst_pkg::IDX_W'(1);
      end
    end
  end

  // One read and one write per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_id    <= id_mem[rd_addr];
      rd_score <= score_mem[rd_addr];
      rd_idx   <= idx;
    end
    if (wr_en) begin
      id_mem[wr_addr]    <= it_id;
      score_mem[wr_addr] <= it_score;
    end
  end

  // The scan looks for the first identifier match, the lowest entry's score and the
  // smallest score among the other entries (first one on a tie).
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found      <= 1'b0;
      second_ok  <= 1'b0;
      second     <= '1;
      found_idx  <= '0;
      second_idx <= '0;
    end else if (scan_pend) begin
      if (!found && rd_id == it_id) begin
        found       <= 1'b1;
        found_idx   <= rd_idx;
        found_score <= rd_score;
      end
      if (rd_idx == cur_low) begin
        low_score <= rd_score;
      end else if (rd_score < second) begin
        second     <= rd_score;
        second_idx <= rd_idx;
        second_ok  <= 1'b1;
      end
    end
  end

  always_comb begin
    full     = (cur_count == tkst_pkg::CNT_W'(tkst_pkg::ENTRIES));
    wr_en    = 1'b0;
    wr_idx   = found_idx;
    low_we   = 1'b0;
    low_next = second_idx;
    cnt_we   = 1'b0;
    cnt_next = cur_count + tkst_pkg::CNT_W'(1);
    if (cmd.decide && (!full || it_score > low_score)) begin
      priority if (found) begin
        if (found_score < it_score) begin
          wr_en = 1'b1;
          if (found_idx == cur_low && second_ok && second < it_score) begin
            low_we = 1'b1;
          end
        end
      end else if (cur_count == '0) begin
        wr_en    = 1'b1;
        wr_idx   = '0;
        low_we   = 1'b1;
        low_next = '0;
        cnt_we   = 1'b1;
      end else if (!full) begin
        wr_en  = 1'b1;
        wr_idx = tkst_pkg::IDX_W'(cur_count);
        cnt_we = 1'b1;
        if (it_score < low_score) begin
          low_we   = 1'b1;
          low_next = tkst_pkg::IDX_W'(cur_count);
        end
      end else begin
        wr_en  = 1'b1;
        wr_idx = cur_low;
        if (second_ok && second < it_score) begin
          low_we = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < tkst_pkg::GROUPS; g++) begin
        grp_count[g] <= '0;
        grp_low[g]   <= '0;
        grp_seal[g]  <= 1'b0;
        grp_day[g]   <= '0;
      end
    end else begin
      if (cmd.day_clear) begin
        grp_count[gidx] <= '0;
        grp_low[gidx]   <= '0;
        grp_seal[gidx]  <= 1'b0;
        grp_day[gidx]   <= it_day;
      end
      if (cmd.seal) begin
        grp_seal[gidx] <= 1'b1;
      end
      if (low_we) begin
        grp_low[gidx] <= low_next;
      end
      if (cnt_we) begin
        grp_count[gidx] <= cnt_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ack || cmd.out_entry) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ack) begin
      out_entry_valid <= 1'b0;
      out_player_id   <= '0;
      out_score       <= '0;
      out_last        <= 1'b1;
    end else if (cmd.out_entry) begin
      out_entry_valid <= 1'b1;
      out_player_id   <= rd_id;
      out_score       <= rd_score;
      out_last        <= status.idx_last;
    end
  end

endmodule

/* src/top_k_score_table_unit.sv */
// Top level of the top-k score table: stream ports, controller and datapath.
//
// The block keeps one leaderboard per group, each holding up to ENTRIES pairs of player
// identifier and best score plus the index of its lowest entry. Every input transaction
// carries a kind in tuser: a submit offers a score (a new day first clears the group, a
// sealed group ignores it, a full table takes it only if it beats the lowest entry), a
// seal freezes the group until the next day change, and a read returns every stored
// entry in order with tlast on the final one. Submits, seals, reads of an empty group and
// transactions with an unknown kind or a group out of range return a single
// acknowledge (tuser 0, tdata 0, tlast 1). The block works on one transaction at a time.
// All entries live in one single-port-read memory, so a submit to a group holding n
// entries walks them one read per cycle, and an empty group or a new day skips the walk.
// A read fetches one entry at a time from memory and loads it into the output register,
// waiting while the sink stalls. The result sits in an output register, so the next
// transaction is taken while the acknowledge of the previous one still waits. No
// clearing pass runs after reset.
module top_k_score_table_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // group [1:0], player_id [33:2], score [65:34], day_index [81:66], zero fill above
  input  logic [tkst_pkg::S_DATA_W-1:0] s_tdata,
  // kind [1:0]
  input  logic [tkst_pkg::KIND_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_player_id [31:0], out_score [63:32]
  output logic [tkst_pkg::M_DATA_W-1:0] m_tdata,
  // entry_valid [0]
  output logic [0:0]                    m_tuser,
  output logic                          m_tlast
);

  tkst_pkg::tkst_cmd_t    cmd;
  tkst_pkg::tkst_status_t status;

  logic [tkst_pkg::ID_W-1:0]    out_player_id;
  logic [tkst_pkg::SCORE_W-1:0] out_score;
  logic                         out_entry_valid;

  tkst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tkst_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (s_tuser),
    .in_group        (s_tdata[tkst_pkg::S_GROUP_LSB +: tkst_pkg::GROUP_W]),
    .in_player_id    (s_tdata[tkst_pkg::S_ID_LSB +: tkst_pkg::ID_W]),
    .in_score        (s_tdata[tkst_pkg::S_SCORE_LSB +: tkst_pkg::SCORE_W]),
    .in_day_index    (s_tdata[tkst_pkg::S_DAY_LSB +: tkst_pkg::DAY_W]),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_entry_valid (out_entry_valid),
    .out_player_id   (out_player_id),
    .out_score       (out_score),
    .out_last        (m_tlast)
  );

  assign m_tdata = {out_score, out_player_id};
  assign m_tuser = out_entry_valid;

endmodule

/* src/tkst_checker.sv */
// Port-level checker for the top-k score table, bound to the top level.
module tkst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tkst_pkg::S_DATA_W-1:0] s_tdata,
  input logic [tkst_pkg::KIND_W-1:0]   s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tkst_pkg::M_DATA_W-1:0] m_tdata,
  input logic [0:0]                    m_tuser,
  input logic                          m_tlast
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output transaction changed while stalled");

  // An acknowledge carries no entry and always closes its run.
  a_ack_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0)
    else $error("acknowledge with payload or without tlast");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a transaction is in progress");

endmodule

bind top_k_score_table_unit tkst_checker u_tkst_checker (.*);
